FILE: design/gpr_pkg.sv
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared constants and types for the grid path reachability block.
// ----------------------------------------------------------------------------
package gpr_pkg;

   // payload field widths
   localparam int ROW_FIELD_W = 6;
   localparam int COL_FIELD_W = 6;
   localparam int LIM_REG_W   = 7;
   localparam int CSR_IDX_W   = 1;

   // commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;

   localparam logic [LIM_REG_W-1:0] LIM_RESET = 7'd64;

   // write-side controls of the cell map (bit enables per field)
   typedef struct packed {
      logic wall_we;
      logic visit_we;
      logic wall_bit;
      logic visit_bit;
   } cell_wr_type;

   // read data of the cell map
   typedef struct packed {
      logic wall;
      logic visited;
   } cell_rd_type;

   // stack controls
   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } stack_ctl_type;

   // stack status
   typedef struct packed {
      logic empty;
      logic full;
   } stack_stat_type;

endpackage

FILE: design/gpr_req_if.sv
// ----------------------------------------------------------------------------
// gpr_req_if
// Request channel: cell writes and reachability queries.
// ----------------------------------------------------------------------------
interface gpr_req_if
   import gpr_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   command;
   logic [ROW_FIELD_W-1:0] row;
   logic [COL_FIELD_W-1:0] col;
   logic                   wall;
   logic [ROW_FIELD_W-1:0] target_row;
   logic [COL_FIELD_W-1:0] target_col;

   modport source (output valid, command, row, col, wall, target_row, target_col,
                   input ready);
   modport sink   (input valid, command, row, col, wall, target_row, target_col,
                   output ready);
endinterface

FILE: design/gpr_rsp_if.sv
// ----------------------------------------------------------------------------
// gpr_rsp_if
// Response channel: one beat per request.
// ----------------------------------------------------------------------------
interface gpr_rsp_if
   import gpr_pkg::*;
();
   logic valid;
   logic ready;
   logic was_query;
   logic reachable;

   modport source (output valid, was_query, reachable, input ready);
   modport sink   (input valid, was_query, reachable, output ready);
endinterface

FILE: design/gpr_csr_if.sv
// ----------------------------------------------------------------------------
// gpr_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface gpr_csr_if
   import gpr_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [LIM_REG_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/grid_path_reachability_top.sv
// ----------------------------------------------------------------------------
// grid_path_reachability_top
// Wall grid with depth-first reachability search over 4-connected open cells.
// ----------------------------------------------------------------------------
// Write beat: the response is registered and raised in the cycle after accept.
// Query with start equal to target or a cell outside the active area: the
// response is likewise raised in the cycle after accept. Other queries first
// clear the visited bits of every address, seed the start cell, then expand
// each cell by a pop, a load, four neighbor reads and a drain step, reading
// the cell map and stack memories through registered ports. One item is in
// work at a time. After reset the cell map is cleared over every address
// before the first request is taken.
module grid_path_reachability_top
   import gpr_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input logic    clock,
   input logic    reset,
   gpr_req_if.sink   req_bus,
   gpr_rsp_if.source rsp_bus,
   gpr_csr_if.sink   csr_bus
);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int RLIM_W = ($clog2(MAX_ROWS + 1) > LIM_REG_W) ?
                           $clog2(MAX_ROWS + 1) : LIM_REG_W;
   localparam int CLIM_W = ($clog2(MAX_COLS + 1) > LIM_REG_W) ?
                           $clog2(MAX_COLS + 1) : LIM_REG_W;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SWEEP  = 3'd2;
   localparam logic [2:0] S_SEED   = 3'd3;
   localparam logic [2:0] S_EXPAND = 3'd4;
   localparam logic [2:0] S_NEXT   = 3'd5;
   localparam logic [2:0] S_LOAD   = 3'd6;

   localparam logic [2:0] DIR_LEFT  = 3'd0;
   localparam logic [2:0] DIR_RIGHT = 3'd1;
   localparam logic [2:0] DIR_UP    = 3'd2;
   localparam logic [2:0] DIR_DOWN  = 3'd3;
   localparam logic [2:0] DIR_DONE  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [2:0]           dir_ff, dir_in;
   logic [ADDR_W-1:0]    sweep_ff, sweep_in;
   logic [ROW_W-1:0]     cur_row_ff, cur_row_in;
   logic [COL_W-1:0]     cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]     tgt_row_ff, tgt_row_in;
   logic [COL_W-1:0]     tgt_col_ff, tgt_col_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [ADDR_W-1:0]    chk_addr_ff, chk_addr_in;
   logic [LIM_REG_W-1:0] rows_ff, cols_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_query_ff, rsp_query_in;
   logic                 rsp_reach_ff, rsp_reach_in;

   logic [RLIM_W-1:0] row_lim;
   logic [CLIM_W-1:0] col_lim;
   logic              req_fire;
   logic              in_storage;
   logic              in_area;
   logic              same_cell;

   logic              nb_ok;
   logic [ROW_W-1:0]  nb_row;
   logic [COL_W-1:0]  nb_col;

   cell_wr_type       cell_wr;
   logic [ADDR_W-1:0] cell_wr_addr;
   logic              cell_rd_en;
   cell_rd_type       cell_rd;

   stack_ctl_type     stk_ctl;
   stack_stat_type    stk_stat;
   logic [ADDR_W-1:0] stk_rd;

   // register values above the storage size act as the storage size
   assign row_lim = (RLIM_W'(rows_ff) > RLIM_W'(MAX_ROWS)) ? RLIM_W'(MAX_ROWS)
                                                           : RLIM_W'(rows_ff);
   assign col_lim = (CLIM_W'(cols_ff) > CLIM_W'(MAX_COLS)) ? CLIM_W'(MAX_COLS)
                                                           : CLIM_W'(cols_ff);

   assign req_bus.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign in_storage = (32'(req_bus.row) < MAX_ROWS) && (32'(req_bus.col) < MAX_COLS);
   assign in_area    = (RLIM_W'(req_bus.row) < row_lim)
                    && (CLIM_W'(req_bus.col) < col_lim)
                    && (RLIM_W'(req_bus.target_row) < row_lim)
                    && (CLIM_W'(req_bus.target_col) < col_lim);
   assign same_cell  = (req_bus.row == req_bus.target_row)
                    && (req_bus.col == req_bus.target_col);

   // neighbor selected by the expand step
   always_comb begin
      nb_ok  = 1'b0;
      nb_row = cur_row_ff;
      nb_col = cur_col_ff;
      unique case (dir_ff)
         DIR_LEFT: begin
            nb_ok  = (cur_col_ff != '0);
            nb_col = cur_col_ff - COL_W'(1);
         end
         DIR_RIGHT: begin
            nb_ok  = (CLIM_W'(cur_col_ff) + CLIM_W'(1)) < col_lim;
            nb_col = cur_col_ff + COL_W'(1);
         end
         DIR_UP: begin
            nb_ok  = (cur_row_ff != '0);
            nb_row = cur_row_ff - ROW_W'(1);
         end
         DIR_DOWN: begin
            nb_ok  = (RLIM_W'(cur_row_ff) + RLIM_W'(1)) < row_lim;
            nb_row = cur_row_ff + ROW_W'(1);
         end
         default: begin
            nb_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      dir_in       = dir_ff;
      sweep_in     = sweep_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      tgt_row_in   = tgt_row_ff;
      tgt_col_in   = tgt_col_ff;
      chk_valid_in = 1'b0;
      chk_addr_in  = {nb_row, nb_col};
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_query_in = rsp_query_ff;
      rsp_reach_in = rsp_reach_ff;
      cell_wr      = '0;
      cell_wr_addr = sweep_ff;
      cell_rd_en   = 1'b0;
      stk_ctl      = '0;

      unique case (state_ff)
         S_CLEAR: begin
            cell_wr.wall_we  = 1'b1;
            cell_wr.visit_we = 1'b1;
            sweep_in         = sweep_ff + ADDR_W'(1);
            if (&sweep_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               rsp_valid_in = 1'b1;
               rsp_query_in = (req_bus.command == CMD_QUERY);
               rsp_reach_in = 1'b0;
               if (req_bus.command == CMD_WRITE) begin
                  cell_wr.wall_we  = in_storage;
                  cell_wr.wall_bit = req_bus.wall;
                  cell_wr_addr     = {ROW_W'(req_bus.row), COL_W'(req_bus.col)};
               end else if (same_cell) begin
                  rsp_reach_in = 1'b1;
               end else if (in_area) begin
                  rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
                  cur_row_in   = ROW_W'(req_bus.row);
                  cur_col_in   = COL_W'(req_bus.col);
                  tgt_row_in   = ROW_W'(req_bus.target_row);
                  tgt_col_in   = COL_W'(req_bus.target_col);
                  sweep_in     = '0;
                  state_in     = S_SWEEP;
               end
            end
         end
         S_SWEEP: begin
            cell_wr.visit_we = 1'b1;
            sweep_in         = sweep_ff + ADDR_W'(1);
            if (&sweep_ff) begin
               state_in = S_SEED;
            end
         end
         S_SEED: begin
            // start cell counts as visited even when it is a wall
            cell_wr.visit_we  = 1'b1;
            cell_wr.visit_bit = 1'b1;
            cell_wr_addr      = {cur_row_ff, cur_col_ff};
            stk_ctl.clear     = 1'b1;
            dir_in            = DIR_LEFT;
            state_in          = S_EXPAND;
         end
         S_EXPAND: begin
            // read neighbor now, test and mark the previous one
            if (dir_ff != DIR_DONE) begin
               cell_rd_en   = nb_ok;
               chk_valid_in = nb_ok;
            end
            if (chk_valid_ff && !cell_rd.wall && !cell_rd.visited) begin
               cell_wr.visit_we  = 1'b1;
               cell_wr.visit_bit = 1'b1;
               cell_wr_addr      = chk_addr_ff;
               stk_ctl.push      = 1'b1;
            end
            dir_in = dir_ff + 3'd1;
            if (dir_ff == DIR_DONE) begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (stk_stat.empty) begin
               rsp_valid_in = 1'b1;
               rsp_query_in = 1'b1;
               rsp_reach_in = 1'b0;
               state_in     = S_IDLE;
            end else begin
               stk_ctl.pop = 1'b1;
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            cur_row_in = stk_rd[ADDR_W-1:COL_W];
            cur_col_in = stk_rd[COL_W-1:0];
            if (stk_rd == {tgt_row_ff, tgt_col_ff}) begin
               rsp_valid_in = 1'b1;
               rsp_query_in = 1'b1;
               rsp_reach_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               dir_in   = DIR_LEFT;
               state_in = S_EXPAND;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         dir_ff       <= DIR_LEFT;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         dir_ff       <= dir_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_row_ff   <= cur_row_in;
      cur_col_ff   <= cur_col_in;
      tgt_row_ff   <= tgt_row_in;
      tgt_col_ff   <= tgt_col_in;
      chk_addr_ff  <= chk_addr_in;
      rsp_query_ff <= rsp_query_in;
      rsp_reach_ff <= rsp_reach_in;
   end

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= LIM_RESET;
         cols_ff <= LIM_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_ROWS: rows_ff <= csr_bus.data;
            CSR_COLS: cols_ff <= csr_bus.data;
            default:  rows_ff <= rows_ff;
         endcase
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.was_query = rsp_query_ff;
   assign rsp_bus.reachable = rsp_reach_ff;

   gpr_cell_map #(
      .ADDR_W (ADDR_W)
   ) u_cell_map (
      .clock   (clock),
      .wr      (cell_wr),
      .wr_addr (cell_wr_addr),
      .rd_en   (cell_rd_en),
      .rd_addr ({nb_row, nb_col}),
      .rd      (cell_rd)
   );

   gpr_search_stack #(
      .ADDR_W (ADDR_W)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .ctl       (stk_ctl),
      .push_data (chk_addr_ff),
      .rd_data   (stk_rd),
      .stat      (stk_stat)
   );

   // a neighbor read never hits the cell being marked in the same cycle
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (cell_rd_en && cell_wr.visit_we) |-> ({nb_row, nb_col} != cell_wr_addr))
      else $error("cell map read and write collide");

   // each cell is pushed at most once, so the stack never overflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      stk_ctl.push |-> !stk_stat.full)
      else $error("search stack overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      stk_ctl.pop |-> !stk_stat.empty)
      else $error("search stack underflow");

   // a response appears only from accept, a found target or an empty stack
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_IDLE || $past(state_ff) == S_NEXT
                               || $past(state_ff) == S_LOAD))
      else $error("response raised from unexpected state");

endmodule

FILE: design/gpr_cell_map.sv
// ----------------------------------------------------------------------------
// gpr_cell_map
// Per-cell wall and visited bits in one memory with bit write enables,
// one write and one registered read port.
// ----------------------------------------------------------------------------
module gpr_cell_map
   import gpr_pkg::*;
#(
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  cell_wr_type       wr,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output cell_rd_type       rd
);
   localparam int WALL_BIT  = 0;
   localparam int VISIT_BIT = 1;

   logic [1:0] mem_ff [2**ADDR_W];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.wall_we) begin
         mem_ff[wr_addr][WALL_BIT] <= wr.wall_bit;
      end
      if (wr.visit_we) begin
         mem_ff[wr_addr][VISIT_BIT] <= wr.visit_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd.wall    = rd_data_ff[WALL_BIT];
   assign rd.visited = rd_data_ff[VISIT_BIT];

endmodule

FILE: design/gpr_search_stack.sv
// ----------------------------------------------------------------------------
// gpr_search_stack
// Search stack of cell addresses in a memory, with its pointer.
// Pop data is registered and valid the cycle after the pop.
// ----------------------------------------------------------------------------
module gpr_search_stack
   import gpr_pkg::*;
#(
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  stack_ctl_type     ctl,
   input  logic [ADDR_W-1:0] push_data,
   output logic [ADDR_W-1:0] rd_data,
   output stack_stat_type    stat
);
   logic [ADDR_W-1:0] mem_ff [2**ADDR_W];
   logic [ADDR_W:0]   sp_ff;
   logic [ADDR_W:0]   sp_in;
   logic [ADDR_W:0]   sp_dec;
   logic [ADDR_W-1:0] rd_data_ff;

   assign sp_dec = sp_ff - (ADDR_W+1)'(1);

   always_comb begin
      sp_in = sp_ff;
      if (ctl.clear) begin
         sp_in = '0;
      end else if (ctl.push) begin
         sp_in = sp_ff + (ADDR_W+1)'(1);
      end else if (ctl.pop) begin
         sp_in = sp_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem_ff[sp_ff[ADDR_W-1:0]] <= push_data;
      end
      if (ctl.pop) begin
         rd_data_ff <= mem_ff[sp_dec[ADDR_W-1:0]];
      end
   end

   assign rd_data    = rd_data_ff;
   assign stat.empty = (sp_ff == '0);
   assign stat.full  = sp_ff[ADDR_W];

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for grid_path_reachability_top. Cell writes and
// reachability queries go in on the request channel, and an in-bench
// depth-first search predicts every response beat. Directed tests cover the
// grid corners, register extremes, area edges and wall cases. Random phases
// then build mazes, most of them small, and query them under several area
// settings, with random idle on both sides in all but one phase.
// ----------------------------------------------------------------------------
module tb;
   import gpr_pkg::*;

   localparam int GRID_ROWS   = 64;
   localparam int GRID_COLS   = 64;
   localparam int GRID_CELLS  = GRID_ROWS * GRID_COLS;
   localparam int IDLE_PCT    = 7;
   localparam int WALL_PCT    = 35;
   localparam int TAIL_CYCLES = 64;
   // the worst query sweeps and then searches the whole grid; the limit sits well above it
   localparam int STALL_LIMIT = 250000;

   typedef struct packed {
      logic was_query;
      logic reachable;
   } answer_type;

   logic clock = 1'b0;
   logic reset;

   gpr_req_if req_bus ();
   gpr_rsp_if rsp_bus ();
   gpr_csr_if csr_bus ();

   grid_path_reachability_top #(
      .MAX_ROWS (GRID_ROWS),
      .MAX_COLS (GRID_COLS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   bit                   wall_grid [GRID_CELLS];
   bit                   dfs_seen  [GRID_CELLS];
   int                   dfs_stack [$];
   logic [LIM_REG_W-1:0] rows_lim;
   logic [LIM_REG_W-1:0] cols_lim;

   answer_type pending_answers [$];
   int         mismatch_count = 0;
   int         stall_count = 0;
   bit         no_idle;

   function automatic void push_open_cell(input int r, input int c);
      int idx;
      idx = r * GRID_COLS + c;
      if (wall_grid[idx] || dfs_seen[idx]) return;
      dfs_seen[idx] = 1'b1;
      dfs_stack.push_back(idx);
   endfunction

   function automatic logic predict_reach(input int sr, input int sc,
                                          input int tr, input int tc);
      int nr, nc, goal, idx, r, c;
      nr = (rows_lim > GRID_ROWS) ? GRID_ROWS : int'(rows_lim);
      nc = (cols_lim > GRID_COLS) ? GRID_COLS : int'(cols_lim);
      foreach (dfs_seen[i]) dfs_seen[i] = 1'b0;
      dfs_stack.delete();
      if (sr == tr && sc == tc) return 1'b1;
      if (sr >= nr || sc >= nc || tr >= nr || tc >= nc) return 1'b0;
      goal = tr * GRID_COLS + tc;
      // start is seeded even when it is a wall
      dfs_seen[sr * GRID_COLS + sc] = 1'b1;
      dfs_stack.push_back(sr * GRID_COLS + sc);
      while (dfs_stack.size() > 0) begin
         idx = dfs_stack.pop_back();
         r   = idx / GRID_COLS;
         c   = idx % GRID_COLS;
         if (idx == goal) return 1'b1;
         if (c > 0)      push_open_cell(r, c - 1);
         if (c + 1 < nc) push_open_cell(r, c + 1);
         if (r > 0)      push_open_cell(r - 1, c);
         if (r + 1 < nr) push_open_cell(r + 1, c);
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic drive_req(input logic cmd,
                            input logic [ROW_FIELD_W-1:0] r,
                            input logic [COL_FIELD_W-1:0] c,
                            input logic w,
                            input logic [ROW_FIELD_W-1:0] tr,
                            input logic [COL_FIELD_W-1:0] tc);
      answer_type ans;
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.row        <= r;
      req_bus.col        <= c;
      req_bus.wall       <= w;
      req_bus.target_row <= tr;
      req_bus.target_col <= tc;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (cmd == CMD_WRITE) begin
         wall_grid[int'(r) * GRID_COLS + int'(c)] = w;
         ans.was_query = 1'b0;
         ans.reachable = 1'b0;
      end else begin
         ans.was_query = 1'b1;
         ans.reachable = predict_reach(int'(r), int'(c), int'(tr), int'(tc));
      end
      pending_answers.push_back(ans);
   endtask

   task automatic write_cell(input int r, input int c, input logic w);
      drive_req(CMD_WRITE, ROW_FIELD_W'(r), COL_FIELD_W'(c), w,
                ROW_FIELD_W'($urandom_range(63)), COL_FIELD_W'($urandom_range(63)));
   endtask

   task automatic query_path(input int sr, input int sc, input int tr, input int tc);
      drive_req(CMD_QUERY, ROW_FIELD_W'(sr), COL_FIELD_W'(sc), 1'($urandom_range(1)),
                ROW_FIELD_W'(tr), COL_FIELD_W'(tc));
   endtask

   // drop valid and wait for every outstanding beat to come back
   task automatic drain_answers();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [LIM_REG_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      if (idx == CSR_ROWS) rows_lim = value;
      else if (idx == CSR_COLS) cols_lim = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_area(input int rows, input int cols);
      drain_answers();
      csr_write(CSR_ROWS, LIM_REG_W'(rows));
      csr_write(CSR_COLS, LIM_REG_W'(cols));
   endtask

   always @(negedge clock) begin
      rsp_bus.ready <= !reset && (no_idle || $urandom_range(99) >= IDLE_PCT);
   end

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin : check_rsp
      answer_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected response beat: expected none, got was_query=%0b reachable=%0b",
                     $realtime, rsp_bus.was_query, rsp_bus.reachable);
            mismatch_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_bus.was_query !== want.was_query) begin
               $display("%0t: was_query mismatch: expected %0b, got %0b",
                        $realtime, want.was_query, rsp_bus.was_query);
               mismatch_count++;
            end
            if (rsp_bus.reachable !== want.reachable) begin
               $display("%0t: reachable mismatch: expected %0b, got %0b",
                        $realtime, want.reachable, rsp_bus.reachable);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
          (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1)) begin
         stall_count = 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $realtime, stall_count);
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_count++;
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_default_grid();
      // reset area is the whole grid, all open
      query_path(0, 0, 63, 63);
      query_path(63, 63, 63, 63);
   endtask

   task automatic test_cell_extremes();
      no_idle = 1'b1;
      write_cell(0, 0, 1'b1);
      write_cell(63, 63, 1'b1);
      write_cell(0, 63, 1'b1);
      write_cell(63, 0, 1'b1);
      no_idle = 1'b0;
      // start is a wall, target is a wall: never reached
      query_path(0, 0, 63, 63);
      write_cell(63, 63, 1'b0);
      write_cell(0, 0, 1'b0);
   endtask

   task automatic test_register_limits();
      set_area(0, 0);
      query_path(5, 5, 5, 5);
      query_path(0, 0, 0, 1);
      // oversized values clamp to the full grid
      set_area(127, 127);
      query_path(1, 1, 1, 2);
      set_area(1, 64);
      query_path(0, 1, 0, 62);
      write_cell(0, 30, 1'b1);
      query_path(0, 1, 0, 62);
      write_cell(0, 30, 1'b0);
      set_area(64, 1);
      query_path(1, 0, 62, 0);
   endtask

   task automatic test_area_edges();
      set_area(4, 4);
      query_path(4, 0, 0, 0);
      query_path(0, 0, 0, 4);
      query_path(10, 10, 10, 10);
      write_cell(1, 1, 1'b1);
      query_path(1, 1, 2, 2);
      query_path(0, 0, 1, 1);
      write_cell(1, 1, 1'b0);
   endtask

   task automatic test_random_mazes();
      int rows, cols, roll;
      for (int phase = 0; phase < 6; phase++) begin
         rows = (phase == 3) ? $urandom_range(65, 127) : $urandom_range(2, 7);
         cols = (phase == 4) ? GRID_COLS : $urandom_range(2, 7);
         set_area(rows, cols);
         if (rows > GRID_ROWS) rows = GRID_ROWS;
         // one phase runs back to back on both sides
         no_idle = (phase == 0);
         for (int n = 0; n < 13; n++) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
               drive_req(1'($urandom_range(1)), ROW_FIELD_W'($urandom_range(63)),
                         COL_FIELD_W'($urandom_range(63)), 1'($urandom_range(1)),
                         ROW_FIELD_W'($urandom_range(63)),
                         COL_FIELD_W'($urandom_range(63)));
            end else if (roll < 55) begin
               write_cell($urandom_range(rows - 1), $urandom_range(cols - 1),
                          $urandom_range(99) < WALL_PCT);
            end else begin
               query_path($urandom_range(rows - 1), $urandom_range(cols - 1),
                          $urandom_range(rows - 1), $urandom_range(cols - 1));
            end
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_WRITE;
      req_bus.row        = '0;
      req_bus.col        = '0;
      req_bus.wall       = 1'b0;
      req_bus.target_row = '0;
      req_bus.target_col = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_ROWS;
      csr_bus.data       = '0;
      rows_lim           = LIM_RESET;
      cols_lim           = LIM_RESET;
      no_idle            = 1'b0;
      foreach (wall_grid[i]) wall_grid[i] = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_grid();
      test_cell_extremes();
      test_register_limits();
      test_area_edges();
      test_random_mazes();

      drain_answers();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: grid_path_reachability_top.f
design/gpr_pkg.sv
design/gpr_req_if.sv
design/gpr_rsp_if.sv
design/gpr_csr_if.sv
design/gpr_cell_map.sv
design/gpr_search_stack.sv
design/grid_path_reachability_top.sv
dv/tb.sv
